>>> rtl/fps_pkg.sv
// shared types and constants for the fenwick prefix-sum block
`timescale 1ns / 1ps
package fps_pkg;

    localparam int unsigned INDEX_W      = 11;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned SIZE_DEFAULT = 1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } fps_state_t;

    typedef struct packed {
        logic load;
        logic clear_en;
        logic walk_en;
    } fps_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic walk_done;
        logic op_query;
    } fps_stat_t;

endpackage

>>> rtl/fps_datapath.sv
// node memory, walk position, accumulator and clear counter
`timescale 1ns / 1ps
module fps_datapath #(
    parameter int unsigned SIZE = fps_pkg::SIZE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fps_pkg::fps_cmd_t                 cmd,
    input  logic                              op,
    input  logic [fps_pkg::INDEX_W-1:0]       index,
    input  logic [fps_pkg::DATA_W-1:0]        delta,
    output fps_pkg::fps_stat_t                stat,
    output logic [fps_pkg::DATA_W-1:0]        acc
);
    import fps_pkg::*;

    localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int unsigned PW = (AW + 2 > INDEX_W + 1) ? AW + 2 : INDEX_W + 1;
    localparam logic [PW-1:0] SIZE_P   = PW'(SIZE);
    localparam logic [AW-1:0] CLR_LAST = AW'(SIZE - 1);

    logic [DATA_W-1:0] mem [SIZE];

    logic              op_reg;
    logic [DATA_W-1:0] delta_reg;
    logic [PW-1:0]     pos_reg,    pos_next;
    logic [DATA_W-1:0] acc_reg,    acc_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [AW-1:0]     clr_reg,    clr_next;
    logic [AW-1:0]     rd_addr_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic [PW-1:0]     index_p;
    logic [PW-1:0]     pos_start;
    logic [PW-1:0]     low_bit;
    logic [PW-1:0]     pos_up;
    logic [PW-1:0]     pos_down;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb
    begin
        index_p  = PW'(index);
        low_bit  = pos_reg & (~pos_reg + PW'(1));
        pos_up   = pos_reg + low_bit;
        pos_down = pos_reg & (pos_reg - PW'(1));
        rd_en    = cmd.walk_en && (pos_reg != '0);
        rd_addr  = AW'(pos_reg - PW'(1));

        if (op == OP_QUERY)
        begin
            pos_start = (index_p > SIZE_P) ? SIZE_P : index_p;
        end
        else
        begin
            pos_start = (index_p > SIZE_P) ? '0 : index_p;
        end

        // add walks upward, query strips low bits
        pos_next = pos_reg;
        if (cmd.load)
        begin
            pos_next = pos_start;
        end
        else if (rd_en)
        begin
            if (op_reg == OP_QUERY)
            begin
                pos_next = pos_down;
            end
            else
            begin
                pos_next = (pos_up > SIZE_P) ? '0 : pos_up;
            end
        end

        acc_next = acc_reg;
        if (cmd.load)
        begin
            acc_next = '0;
        end
        else if (cmd.walk_en && rd_vld_reg && (op_reg == OP_QUERY))
        begin
            acc_next = acc_reg + rdata_reg;
        end

        rd_vld_next = rd_en;
        clr_next    = cmd.clear_en ? clr_reg + AW'(1) : clr_reg;

        // sweep zeros after reset, else write back updated node
        if (cmd.clear_en)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.walk_en && rd_vld_reg && (op_reg == OP_ADD);
            wr_addr = rd_addr_reg;
            wr_data = rdata_reg + delta_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            acc_reg    <= '0;
            rd_vld_reg <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            rd_vld_reg <= rd_vld_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= op;
            delta_reg <= delta;
        end
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        stat.clear_done = (clr_reg == CLR_LAST);
        stat.walk_done  = (pos_reg == '0) && !rd_vld_reg;
        stat.op_query   = (op_reg == OP_QUERY);
    end

    assign acc = acc_reg;

endmodule

>>> rtl/fps_ctrl.sv
// controller: clear sweep, idle, tree walk
`timescale 1ns / 1ps
module fps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fps_pkg::fps_stat_t  stat,
    output fps_pkg::fps_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import fps_pkg::*;

    fps_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                done        = stat.walk_done && stat.op_query;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/fenwick_prefix_sum.sv
// top level: fenwick tree with add and prefix-sum query commands
// walk: a beat walks tree nodes (add: up the tree, query: set bits of index),
//   busy stays high after accept until the walk ends; a query's done pulses in the last busy cycle
// a new beat is accepted only while busy is low, once the previous walk has finished;
//   the walk reads one node per cycle and, for an add, writes back the node read before
// reset: busy while the node memory is swept to zero
// the receiver cannot stall; prefix_sum is valid in the done cycle and holds until the next beat is accepted
`timescale 1ns / 1ps
module fenwick_prefix_sum #(
    parameter int unsigned SIZE = fps_pkg::SIZE_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [fps_pkg::INDEX_W-1:0]           index,
    input  logic signed [fps_pkg::DATA_W-1:0]     delta,
    output logic                                  done,
    output logic signed [fps_pkg::DATA_W-1:0]     prefix_sum
);
    import fps_pkg::*;

    fps_cmd_t          cmd;
    fps_stat_t         stat;
    logic [DATA_W-1:0] acc;

    fps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fps_datapath #(
        .SIZE (SIZE)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .op    (op),
        .index (index),
        .delta ($unsigned(delta)),
        .stat  (stat),
        .acc   (acc)
    );

    assign prefix_sum = $signed(acc);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside a walk");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ADD)) |=> !done)
        else $error("add produced a result");

endmodule

>>> tb/fps_checker.sv
// checker: watches the command and result ports, predicts prefix sums and compares
`timescale 1ns / 1ps
module fps_checker #(
    parameter int unsigned SIZE = fps_pkg::SIZE_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  busy,
    input  logic                                  op,
    input  logic [fps_pkg::INDEX_W-1:0]           index,
    input  logic signed [fps_pkg::DATA_W-1:0]     delta,
    input  logic                                  done,
    input  logic signed [fps_pkg::DATA_W-1:0]     prefix_sum,
    output int unsigned                           failures,
    output int unsigned                           pending
);
    import fps_pkg::*;

    logic [DATA_W-1:0] tree_nodes [1:SIZE];
    logic [DATA_W-1:0] sum_q [$];
    logic [DATA_W-1:0] want_sum;
    int unsigned       fail_cnt = 0;
    int unsigned       pend_cnt = 0;

    assign failures = fail_cnt;
    assign pending  = pend_cnt;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_cnt = fail_cnt + 1;
    endtask

    task automatic node_add(input int unsigned pos, input logic [DATA_W-1:0] amount);
        int unsigned p;
        p = pos;
        while (p >= 1 && p <= SIZE)
        begin
            tree_nodes[p] = tree_nodes[p] + amount;
            p = p + (p & (~p + 1));
        end
    endtask

    function automatic logic [DATA_W-1:0] prefix_of(input int unsigned pos);
        logic [DATA_W-1:0] acc;
        int unsigned       p;
        acc = '0;
        p = (pos > SIZE) ? SIZE : pos;
        while (p != 0)
        begin
            acc = acc + tree_nodes[p];
            p = p & (p - 1);
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= SIZE; k++)
                tree_nodes[k] = '0;
            sum_q.delete();
            pend_cnt <= 0;
        end
        else
        begin
            if (done)
            begin
                if (sum_q.size() == 0)
                begin
                    report_mismatch($sformatf("prefix_sum %h with no query waiting",
                                              prefix_sum));
                end
                else
                begin
                    want_sum = sum_q.pop_front();
                    if (prefix_sum !== want_sum)
                        report_mismatch($sformatf("prefix_sum expected %h got %h",
                                                  want_sum, prefix_sum));
                end
            end
            if (start && !busy)
            begin
                if (op == OP_QUERY)
                    sum_q = {sum_q, prefix_of(int'(index))};
                else
                    node_add(int'(index), delta);
            end
            pend_cnt <= sum_q.size();
        end
    end

endmodule

>>> tb/fenwick_prefix_sum_tb.sv
// testbench top: drives add and query beats into the fenwick block and gives the verdict
`timescale 1ns / 1ps
module fenwick_prefix_sum_tb;
    import fps_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic                     clk    = 1'b0;
    logic                     rst_n  = 1'b0;
    logic                     start  = 1'b0;
    logic                     op     = OP_ADD;
    logic [INDEX_W-1:0]       index  = '0;
    logic signed [DATA_W-1:0] delta  = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] prefix_sum;
    int unsigned              failures;
    int unsigned              pending;
    int unsigned              cycles = 0;
    bit                       idle_on = 1'b1;

    fenwick_prefix_sum u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .index      (index),
        .delta      (delta),
        .done       (done),
        .prefix_sum (prefix_sum)
    );

    fps_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .index      (index),
        .delta      (delta),
        .done       (done),
        .prefix_sum (prefix_sum),
        .failures   (failures),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("fenwick_prefix_sum verification failed");
            $finish;
        end
    end

    task automatic send_beat(input logic b_op, input logic [INDEX_W-1:0] b_index,
                             input logic [DATA_W-1:0] b_delta);
        int unsigned gap;
        start <= 1'b1;
        op    <= b_op;
        index <= b_index;
        delta <= b_delta;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic               r_op;
        logic [INDEX_W-1:0] r_index;
        logic [DATA_W-1:0]  r_delta;
        logic [INDEX_W-1:0] last_add;
        int unsigned        pick;

        last_add = 11'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty tree, ignored adds, extremes of index and delta, wrap
        send_beat(OP_QUERY, 11'd0,    32'h0000_0000);
        send_beat(OP_QUERY, 11'd1024, 32'h0000_0000);
        send_beat(OP_ADD,   11'd0,    32'h7FFF_FFFF);
        send_beat(OP_ADD,   11'd1,    32'h7FFF_FFFF);
        send_beat(OP_ADD,   11'd1024, 32'h8000_0000);
        send_beat(OP_ADD,   11'd1025, 32'h0000_0001);
        send_beat(OP_ADD,   11'd2047, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 11'd1,    32'h0000_0000);
        send_beat(OP_QUERY, 11'd1023, 32'h0000_0000);
        send_beat(OP_QUERY, 11'd1024, 32'h0000_0000);
        send_beat(OP_QUERY, 11'd1025, 32'h0000_0000);
        send_beat(OP_QUERY, 11'd2047, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 11'd0,    32'hFFFF_FFFF);
        send_beat(OP_ADD,   11'd512,  32'h7FFF_FFFF);
        send_beat(OP_ADD,   11'd512,  32'h7FFF_FFFF);
        send_beat(OP_QUERY, 11'd512,  32'h0000_0000);
        send_beat(OP_QUERY, 11'd511,  32'h0000_0000);
        send_beat(OP_ADD,   11'd1023, 32'hFFFF_FFFF);
        send_beat(OP_QUERY, 11'd1023, 32'h0000_0000);
        send_beat(OP_ADD,   11'd0,    32'h8000_0000);
        send_beat(OP_QUERY, 11'd2047, 32'h0000_0000);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (i == RANDOM_ITEMS / 2)
                wait_drained();

            r_op = ($urandom_range(0, 99) < 45) ? OP_ADD : OP_QUERY;

            pick = $urandom_range(0, 99);
            if (pick < 4)
                r_index = 11'd0;
            else if (pick < 10)
                r_index = 11'($urandom_range(1025, 2047));
            else if (pick < 20)
            begin
                case ($urandom_range(0, 4))
                    0: r_index = 11'd1;
                    1: r_index = 11'd2;
                    2: r_index = 11'd512;
                    3: r_index = 11'd1023;
                    default: r_index = 11'd1024;
                endcase
            end
            else if (pick < 32 && r_op == OP_QUERY)
                r_index = (last_add > 11'd1 && $urandom_range(0, 1) == 1)
                          ? last_add - 11'd1 : last_add;
            else
                r_index = 11'($urandom_range(1, 1024));

            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                case ($urandom_range(0, 3))
                    0: r_delta = 32'h7FFF_FFFF;
                    1: r_delta = 32'h8000_0000;
                    2: r_delta = 32'hFFFF_FFFF;
                    default: r_delta = 32'h0000_0000;
                endcase
            end
            else if (pick < 50)
                r_delta = 32'($urandom_range(0, 200)) - 32'd100;
            else
                r_delta = $urandom;

            if (r_op == OP_ADD)
                last_add = r_index;
            send_beat(r_op, r_index, r_delta);
        end

        wait_drained();
        repeat (20) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("fenwick_prefix_sum verification clean");
        else
            $display("fenwick_prefix_sum verification failed");
        $finish;
    end

endmodule
